@@ rtl/software_timer_task_table_defines.svh @@
// assertion macros shared by the timer table checks
`ifndef SOFTWARE_TIMER_TASK_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TASK_TABLE_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define STT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table check failed");

// next-cycle implication, skipped while reset is high
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

@@ rtl/stt_pkg.sv @@
// shared types and constants of the software timer table
`default_nettype none

package stt_pkg;

  // default number of timer slots
  localparam int SLOT_COUNT_DEF = 8;

  // most fired items one scan reports
  localparam int MAX_FIRE = 8;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);

  // field widths
  localparam int ID_W = 8;
  localparam int MS_W = 32;
  localparam int SLOT_OUT_W = 3;
  localparam int FUNC_W = 2;

  // packed stream widths
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 16;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_EXISTS = 2'd2,
    FUNC_SCAN   = 2'd3
  } func_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SCAN,
    S_FINISH
  } state_t;

  // one timer slot
  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic [MS_W-1:0] period;
    logic [MS_W-1:0] start;
    logic            reload;
  } entry_t;

  // table write request
  typedef struct packed {
    logic   en;
    logic   keep;
    entry_t entry;
  } tbl_wr_t;

  // shared compare unit results
  typedef struct packed {
    logic match;
    logic due;
  } unit_res_t;

endpackage

`default_nettype wire

@@ rtl/software_timer_task_table.sv @@
// Software timer table: a fixed set of timer slots driven by a command stream.
// The s_ channel takes one command item: add, remove, exists or scan, with the
// current millisecond time. The m_ channel returns result items; add, remove
// and exists give one item, scan gives one item per fired slot in slot order
// (at most eight) or one empty item, and tlast marks the final one.
// A command walks the slot table one slot per cycle through the single table
// read port, comparing each slot in one shared compare unit; a full output
// register can hold the walk. An add, remove or exists registers its result at
// the first slot that matches or at the last slot; a scan registers its final
// item from the finish state once its walk ends.
// s_tready is high only while no command is in progress.
// Reset clears every slot to free at once through per-slot valid bits; no
// clearing pass follows, and the block takes commands in the next cycle.
// When the receiver stalls, the result waits in the output register; a scan
// holding an item stops at the next due slot until the register frees up.
`default_nettype none

module software_timer_task_table #(
  parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command items
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // task_id[7:0], period_ms[39:8], periodic[40], now_ms[72:41], zero pad
  input  wire logic [stt_pkg::IN_DATA_W-1:0]     s_tdata,
  // func[1:0]
  input  wire logic [stt_pkg::FUNC_W-1:0]        s_tuser,
  // result items
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // ok[0], fired_id[8:1], fired_slot[11:9], zero pad
  output logic [stt_pkg::OUT_DATA_W-1:0]         m_tdata,
  // fired[0]
  output logic                                   m_tuser,
  output logic                                   m_tlast
);
  import stt_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         wr_addr;
  entry_t                rd_entry;
  tbl_wr_t               wr;
  logic [ID_W-1:0]       key;
  logic [MS_W-1:0]       now;
  unit_res_t             res;
  logic                  out_ok;
  logic [ID_W-1:0]       out_id;
  logic [SLOT_OUT_W-1:0] out_slot;

  // slot storage
  stt_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_addr  (wr_addr),
    .wr       (wr)
  );

  // shared compare unit
  stt_unit u_unit (
    .entry (rd_entry),
    .key   (key),
    .now   (now),
    .res   (res)
  );

  // sequencer
  stt_seq #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_func     (s_tuser),
    .in_task_id  (s_tdata[7:0]),
    .in_period   (s_tdata[39:8]),
    .in_periodic (s_tdata[40]),
    .in_now      (s_tdata[72:41]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_ok      (out_ok),
    .out_fired   (m_tuser),
    .out_id      (out_id),
    .out_slot    (out_slot),
    .out_last    (m_tlast),
    .rd_addr     (rd_addr),
    .rd_entry    (rd_entry),
    .wr_addr     (wr_addr),
    .wr          (wr),
    .key         (key),
    .now         (now),
    .res         (res)
  );

  // result packing
  assign m_tdata = {4'b0000, out_slot, out_id, out_ok};

endmodule

`default_nettype wire

@@ rtl/stt_table.sv @@
// slot storage: one write port, one registered read port, per-slot valid bits
`default_nettype none

module stt_table #(
  parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF,
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [IW-1:0]   rd_addr,
  output stt_pkg::entry_t      rd_entry,
  input  wire logic [IW-1:0]   wr_addr,
  input  stt_pkg::tbl_wr_t     wr
);
  import stt_pkg::*;

  entry_t                mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;
  logic                  rd_valid;
  entry_t                rd_raw;

  // slot contents, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
    rd_raw <= mem[rd_addr];
  end

  // valid bits, cleared at reset so every slot reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr_addr] <= wr.keep;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  // a slot never written reads as its reset contents
  assign rd_entry = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

@@ rtl/stt_unit.sv @@
// shared compare unit: identifier match and wrapped elapsed-time test
`default_nettype none

module stt_unit (
  input  stt_pkg::entry_t                  entry,
  input  wire logic [stt_pkg::ID_W-1:0]    key,
  input  wire logic [stt_pkg::MS_W-1:0]    now,
  output stt_pkg::unit_res_t               res
);
  import stt_pkg::*;

  logic [MS_W-1:0] elapsed;

  // elapsed time wraps modulo 2^32
  assign elapsed   = now - entry.start;
  assign res.due   = (elapsed >= entry.period);
  assign res.match = (entry.task_id == key);

endmodule

`default_nettype wire

@@ rtl/stt_seq.sv @@
// sequencer: walks the slots one per cycle unless a full output stalls it, and builds result items
`default_nettype none

module stt_seq #(
  parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF,
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command side
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [stt_pkg::FUNC_W-1:0]       in_func,
  input  wire logic [stt_pkg::ID_W-1:0]         in_task_id,
  input  wire logic [stt_pkg::MS_W-1:0]         in_period,
  input  wire logic                             in_periodic,
  input  wire logic [stt_pkg::MS_W-1:0]         in_now,
  // result side
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_ok,
  output logic                                  out_fired,
  output logic [stt_pkg::ID_W-1:0]              out_id,
  output logic [stt_pkg::SLOT_OUT_W-1:0]        out_slot,
  output logic                                  out_last,
  // table
  output logic [IW-1:0]                         rd_addr,
  input  stt_pkg::entry_t                       rd_entry,
  output logic [IW-1:0]                         wr_addr,
  output stt_pkg::tbl_wr_t                      wr,
  // compare unit
  output logic [stt_pkg::ID_W-1:0]              key,
  output logic [stt_pkg::MS_W-1:0]              now,
  input  stt_pkg::unit_res_t                    res
);
  import stt_pkg::*;

  state_t                 state, state_next;
  logic [IW-1:0]          idx, idx_next;
  logic [FIRE_CNT_W-1:0]  cnt, cnt_next;

  // latched command
  func_t                  cmd_func;
  logic [ID_W-1:0]        cmd_id;
  logic [MS_W-1:0]        cmd_period;
  logic                   cmd_periodic;
  logic [MS_W-1:0]        cmd_now;
  logic                   cmd_load;

  // fired item held until the next one shows whether it is the last
  logic                   pend_valid, pend_valid_next;
  logic [ID_W-1:0]        pend_id, pend_id_next;
  logic [SLOT_OUT_W-1:0]  pend_slot, pend_slot_next;

  // output register load
  logic                   out_load;
  logic                   ld_ok, ld_fired, ld_last;
  logic [ID_W-1:0]        ld_id;
  logic [SLOT_OUT_W-1:0]  ld_slot;

  logic                   at_last;
  logic                   out_free;
  logic                   fire;

  assign at_last  = (idx == IW'(SLOT_COUNT - 1));
  assign out_free = !out_valid || out_ready;
  assign fire     = (rd_entry.task_id != '0) && res.due;
  assign key      = (cmd_func == FUNC_ADD) ? '0 : cmd_id;
  assign now      = cmd_now;
  assign in_ready = (state == S_IDLE);
  assign rd_addr  = idx_next;
  assign wr_addr  = idx;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_func     <= func_t'(in_func);
      cmd_id       <= in_task_id;
      cmd_period   <= in_period;
      cmd_periodic <= in_periodic;
      cmd_now      <= in_now;
    end
    pend_id   <= pend_id_next;
    pend_slot <= pend_slot_next;
    if (out_load) begin
      out_ok    <= ld_ok;
      out_fired <= ld_fired;
      out_id    <= ld_id;
      out_slot  <= ld_slot;
      out_last  <= ld_last;
    end
  end

  // next state, table writes and result loads
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    cnt_next        = cnt;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    pend_slot_next  = pend_slot;
    cmd_load        = 1'b0;
    out_load        = 1'b0;
    ld_ok           = 1'b0;
    ld_fired        = 1'b0;
    ld_id           = '0;
    ld_slot         = '0;
    ld_last         = 1'b1;
    wr              = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_load        = 1'b1;
          idx_next        = '0;
          cnt_next        = '0;
          pend_valid_next = 1'b0;
          state_next      = (func_t'(in_func) == FUNC_SCAN) ? S_SCAN : S_SEARCH;
        end
      end
      S_SEARCH: begin
        // first slot holding the key, or end of table
        if (res.match || at_last) begin
          if (out_free) begin
            out_load   = 1'b1;
            ld_ok      = res.match;
            state_next = S_IDLE;
            if (res.match) begin
              case (cmd_func)
                FUNC_ADD: begin
                  wr.en                 = 1'b1;
                  wr.keep               = 1'b1;
                  wr.entry.task_id      = cmd_id;
                  wr.entry.period       = cmd_period;
                  wr.entry.start        = cmd_now;
                  wr.entry.reload       = cmd_periodic;
                end
                FUNC_REMOVE: begin
                  wr.en = 1'b1;
                end
                default: begin
                end
              endcase
            end
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_SCAN: begin
        if (fire) begin
          // a held item can only move on when the output register is free
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_load = 1'b1;
              ld_fired = 1'b1;
              ld_id    = pend_id;
              ld_slot  = pend_slot;
              ld_last  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = rd_entry.task_id;
            pend_slot_next  = SLOT_OUT_W'(idx);
            // periodic slots restart, one-shot slots are freed
            wr.en = 1'b1;
            if (rd_entry.reload) begin
              wr.keep        = 1'b1;
              wr.entry       = rd_entry;
              wr.entry.start = cmd_now;
            end
            cnt_next = cnt + FIRE_CNT_W'(1);
            if (at_last || cnt == FIRE_CNT_W'(MAX_FIRE - 1)) begin
              state_next = S_FINISH;
            end else begin
              idx_next = idx + IW'(1);
            end
          end
        end else if (at_last) begin
          state_next = S_FINISH;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_FINISH: begin
        // final item of a scan, or the empty report
        if (out_free) begin
          out_load        = 1'b1;
          ld_fired        = pend_valid;
          ld_id           = pend_valid ? pend_id : '0;
          ld_slot         = pend_valid ? pend_slot : '0;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/stt_checker.sv @@
// port-level checks of the timer table, bound to the top level
`default_nettype none
`include "software_timer_task_table_defines.svh"

module stt_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [stt_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic                              m_tuser,
  input wire logic                              m_tlast
);

  // a stalled result stays offered
  `STT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // a taken command makes the block busy, so s_tready drops
  `STT_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // an item without a fired task is always the final one
  `STT_ASSERT_NOW(a_empty_is_last, clk, rst, m_tvalid && !m_tuser, m_tlast)

  // a successful add, remove or exists is a single item that fired nothing
  `STT_ASSERT_NOW(a_ok_single, clk, rst, m_tvalid && m_tdata[0], m_tlast && !m_tuser)

  // a fired task always has a real identifier
  `STT_ASSERT_NOW(a_fired_id, clk, rst, m_tvalid && m_tuser, m_tdata[8:1] != 8'd0)

endmodule

bind software_timer_task_table stt_checker u_stt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

@@ verif/software_timer_task_table_tb.sv @@
// testbench for the software timer table: directed and random command streams
module software_timer_task_table_tb;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_SETTLE  = 24;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 64;

  // expected behavior of the slot table and the results it owes
  class timer_slot_tracker;
    typedef struct {
      bit       ok;
      bit       fired;
      bit [7:0] id;
      bit [2:0] slot;
      bit       last;
    } timer_result_t;

    bit [7:0]      slot_id[stt_pkg::SLOT_COUNT_DEF];
    bit [31:0]     slot_period[stt_pkg::SLOT_COUNT_DEF];
    bit [31:0]     slot_start[stt_pkg::SLOT_COUNT_DEF];
    bit            slot_reload[stt_pkg::SLOT_COUNT_DEF];
    timer_result_t awaited_results[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   firings_seen;

    function new();
      for (int i = 0; i < stt_pkg::SLOT_COUNT_DEF; i++) begin
        free_slot(i);
      end
      mismatches   = 0;
      results_seen = 0;
      firings_seen = 0;
    endfunction

    function void free_slot(int idx);
      slot_id[idx]     = '0;
      slot_period[idx] = '0;
      slot_start[idx]  = '0;
      slot_reload[idx] = 1'b0;
    endfunction

    // first slot holding the id, -1 when none
    function int find_slot(bit [7:0] id);
      for (int i = 0; i < stt_pkg::SLOT_COUNT_DEF; i++) begin
        if (slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    function void owe_status(bit ok);
      timer_result_t r;
      r = '{ok: ok, fired: 1'b0, id: 8'd0, slot: 3'd0, last: 1'b1};
      awaited_results.push_back(r);
    endfunction

    // apply one accepted command and queue the results it causes
    function void note_command(stt_pkg::func_t op, bit [7:0] id, bit [31:0] period,
                               bit reload, bit [31:0] now_ms);
      int            idx;
      bit [31:0]     elapsed;
      timer_result_t r;
      timer_result_t fires[$];
      case (op)
        stt_pkg::FUNC_ADD: begin
          idx = find_slot(8'd0);
          if (idx >= 0) begin
            slot_id[idx]     = id;
            slot_period[idx] = period;
            slot_start[idx]  = now_ms;
            slot_reload[idx] = reload;
          end
          owe_status(idx >= 0);
        end
        stt_pkg::FUNC_REMOVE: begin
          idx = find_slot(id);
          if (idx >= 0) free_slot(idx);
          owe_status(idx >= 0);
        end
        stt_pkg::FUNC_EXISTS: begin
          owe_status(find_slot(id) >= 0);
        end
        default: begin
          // fire due slots in slot order, at most one scan's worth
          for (int i = 0; i < stt_pkg::SLOT_COUNT_DEF && fires.size() < stt_pkg::MAX_FIRE;
               i++) begin
            elapsed = now_ms - slot_start[i];
            if (slot_id[i] != 0 && elapsed >= slot_period[i]) begin
              r = '{ok: 1'b0, fired: 1'b1, id: slot_id[i], slot: i[2:0], last: 1'b0};
              fires.push_back(r);
              if (slot_reload[i]) slot_start[i] = now_ms;
              else free_slot(i);
            end
          end
          if (fires.size() == 0) begin
            owe_status(1'b0);
          end else begin
            fires[fires.size()-1].last = 1'b1;
            foreach (fires[k]) awaited_results.push_back(fires[k]);
          end
        end
      endcase
    endfunction

    // compare one accepted result item with the oldest one owed
    function void check_result(bit ok, bit fired, bit [7:0] id, bit [2:0] slot, bit last);
      timer_result_t e;
      results_seen++;
      if (fired) firings_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result item with none owed: ok=%0b fired=%0b id=%0d slot=%0d last=%0b",
                 $time, ok, fired, id, slot, last);
        mismatches++;
        return;
      end
      e = awaited_results.pop_front();
      if (ok != e.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, e.ok, ok);
        mismatches++;
      end
      if (fired != e.fired) begin
        $display("%0t: fired expected %0b actual %0b", $time, e.fired, fired);
        mismatches++;
      end
      if (id != e.id) begin
        $display("%0t: fired_id expected %0d actual %0d", $time, e.id, id);
        mismatches++;
      end
      if (slot != e.slot) begin
        $display("%0t: fired_slot expected %0d actual %0d", $time, e.slot, slot);
        mismatches++;
      end
      if (last != e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [stt_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [stt_pkg::FUNC_W-1:0]    s_tuser = stt_pkg::FUNC_ADD;
  logic                          m_tvalid;
  logic                          m_tready = 1'b1;
  logic [stt_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;

  timer_slot_tracker slots = new();
  bit          send_idle  = 1'b0;
  bit          recv_stall = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned op_count[4] = '{0, 0, 0, 0};
  bit [31:0]   wall_ms;

  software_timer_task_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result items still owed", $time,
               slots.awaited_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver backpressure in random bursts
  always @(posedge clk) begin
    if (recv_stall && stall_left == 0 && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (recv_stall && stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // both handshakes: results first, then the command taken at this edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      slots.check_result(m_tdata[0], m_tuser, m_tdata[8:1], m_tdata[11:9], m_tlast);
    end
    if (!rst && s_tvalid && s_tready) begin
      op_count[s_tuser]++;
      slots.note_command(stt_pkg::func_t'(s_tuser), s_tdata[7:0], s_tdata[39:8],
                         s_tdata[40], s_tdata[72:41]);
    end
  end

  // present one command item and hold it until taken
  task automatic send_command(stt_pkg::func_t op, bit [7:0] id, bit [31:0] period,
                              bit reload, bit [31:0] now_ms);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, now_ms, reload, period, id};
    do @(posedge clk); while (!s_tready);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every owed result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (slots.awaited_results.size() != 0) @(posedge clk);
  endtask

  // mostly plausible timer traffic on a small id set, with some noise
  task automatic send_random_command();
    stt_pkg::func_t op;
    bit [7:0]       id;
    bit [31:0]      period;
    int unsigned    pick;
    if ($urandom_range(0, 19) == 0) wall_ms = $urandom;
    else wall_ms = wall_ms + $urandom_range(0, 40);
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = stt_pkg::FUNC_ADD;
    else if (pick < 45) op = stt_pkg::FUNC_REMOVE;
    else if (pick < 60) op = stt_pkg::FUNC_EXISTS;
    else                op = stt_pkg::FUNC_SCAN;
    pick = $urandom_range(0, 19);
    if (pick == 0)      id = 8'd0;
    else if (pick == 1) id = 8'($urandom_range(0, 255));
    else                id = 8'($urandom_range(1, 12));
    pick = $urandom_range(0, 19);
    if (pick == 0)      period = '0;
    else if (pick == 1) period = '1;
    else if (pick < 4)  period = $urandom;
    else                period = $urandom_range(0, 120);
    send_command(op, id, period, 1'($urandom_range(0, 1)), wall_ms);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table: free slot lookups, empty scan, absent remove
    send_command(stt_pkg::FUNC_EXISTS, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_SCAN, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_REMOVE, 8'd5, 32'd0, 1'b0, 32'hFFFF_FFF0);
    // id zero add writes a slot that stays free, id zero remove clears it
    send_command(stt_pkg::FUNC_ADD, 8'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_REMOVE, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFF0);
    // fill every slot with a mix of periods and modes
    send_command(stt_pkg::FUNC_ADD, 8'd1, 32'd0, 1'b1, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_ADD, 8'd2, 32'd0, 1'b0, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_ADD, 8'd3, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_ADD, 8'd4, 32'd100, 1'b0, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_ADD, 8'd5, 32'd50, 1'b1, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_ADD, 8'd6, 32'h8000_0000, 1'b0, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_ADD, 8'd7, 32'd10, 1'b1, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_ADD, 8'd255, 32'd1, 1'b0, 32'hFFFF_FFF0);
    // full table
    send_command(stt_pkg::FUNC_ADD, 8'd9, 32'd5, 1'b1, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_EXISTS, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFF0);
    send_command(stt_pkg::FUNC_EXISTS, 8'd255, 32'd0, 1'b0, 32'hFFFF_FFF0);
    // scan across the time wrap: some fire, one-shots free up
    send_command(stt_pkg::FUNC_SCAN, 8'd0, 32'd0, 1'b0, 32'h0000_00B8);
    send_command(stt_pkg::FUNC_EXISTS, 8'd0, 32'd0, 1'b0, 32'h0000_00B8);
    send_command(stt_pkg::FUNC_ADD, 8'd10, 32'd0, 1'b0, 32'h0000_00B8);
    send_command(stt_pkg::FUNC_ADD, 8'd11, 32'd0, 1'b1, 32'h0000_00B8);
    send_command(stt_pkg::FUNC_ADD, 8'd12, 32'd0, 1'b0, 32'h0000_00B8);
    // every slot due at once, including the largest period
    send_command(stt_pkg::FUNC_SCAN, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFEF);
    send_command(stt_pkg::FUNC_REMOVE, 8'd255, 32'd0, 1'b0, 32'hFFFF_FFEF);
    send_command(stt_pkg::FUNC_REMOVE, 8'd3, 32'd0, 1'b0, 32'hFFFF_FFEF);
    drain_results();

    // random phases, sender pauses for all results between them
    wall_ms = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      send_idle  = (p != PHASES - 1);
      recv_stall = (p != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_command();
      drain_results();
    end

    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d adds, %0d removes, %0d exists queries and %0d scans",
             op_count[stt_pkg::FUNC_ADD], op_count[stt_pkg::FUNC_REMOVE],
             op_count[stt_pkg::FUNC_EXISTS], op_count[stt_pkg::FUNC_SCAN]);
    $display("checked %0d result items, %0d of them timer firings",
             slots.results_seen, slots.firings_seen);
    if (slots.mismatches == 0 && slots.awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_table.sv
rtl/stt_unit.sv
rtl/stt_seq.sv
rtl/software_timer_task_table.sv
rtl/stt_checker.sv
verif/software_timer_task_table_tb.sv
